>>> hdl/psd_pkg.sv
// Shared widths, word types and chain lengths for the point to segment distance core
`default_nettype none
package psd_pkg;

  localparam int CW        = 24;
  localparam int DW        = CW + 1;
  localparam int PW        = 2 * DW;
  localparam int NW        = PW + 2;
  localparam int QW        = DW + 1;
  localparam int SW        = 2 * DW;
  localparam int RW        = DW;
  localparam int REMW      = RW + 3;
  localparam int OUTW      = CW + 1;
  localparam int DIV_CELLS = 2 * DW;
  localparam int SQRT_CELLS = SW / 2;

  typedef struct packed {
    logic                 strict;
    logic                 off;
    logic                 proj;
    logic                 use_end;
    logic                 neg_x;
    logic                 neg_y;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
  } side_t;

  typedef struct packed {
    logic [NW-1:0] r_x;
    logic [NW-1:0] r_y;
    logic [QW-1:0] q_x;
    logic [QW-1:0] q_y;
    logic [DW-1:0] d_x;
    logic [DW-1:0] d_y;
    logic [NW-1:0] num;
    logic [NW-1:0] den;
    side_t         side;
  } div_word_t;

  typedef struct packed {
    logic                 strict;
    logic                 off;
    logic signed [CW-1:0] fx;
    logic signed [CW-1:0] fy;
  } tail_t;

  typedef struct packed {
    logic [SW-1:0]   s;
    logic [REMW-1:0] rem;
    logic [RW-1:0]   r;
    tail_t           tail;
  } sqrt_word_t;

endpackage
`default_nettype wire

>>> hdl/psd_div_cell.sv
// One shift or add step of the projection quotient, both axes side by side
`default_nettype none
module psd_div_cell
  import psd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      en_i,
  input  wire logic      add_step_i,
  input  wire logic      valid_i,
  input  wire div_word_t word_i,
  output logic           valid_o,
  output div_word_t      word_o
);

  logic      valid_q;
  div_word_t word_q, word_d;
  logic [NW-1:0] tx, ty;
  logic [QW-1:0] qx, qy;

  always_comb begin
    word_d = word_i;
    if (add_step_i) begin
      tx = word_i.d_x[DW-1] ? word_i.r_x + word_i.num : word_i.r_x;
      ty = word_i.d_y[DW-1] ? word_i.r_y + word_i.num : word_i.r_y;
      qx = word_i.q_x;
      qy = word_i.q_y;
      word_d.d_x = {word_i.d_x[DW-2:0], 1'b0};
      word_d.d_y = {word_i.d_y[DW-2:0], 1'b0};
    end else begin
      tx = {word_i.r_x[NW-2:0], 1'b0};
      ty = {word_i.r_y[NW-2:0], 1'b0};
      qx = {word_i.q_x[QW-2:0], 1'b0};
      qy = {word_i.q_y[QW-2:0], 1'b0};
    end
    if (tx >= word_i.den) begin
      tx = tx - word_i.den;
      qx = qx + QW'(1);
    end
    if (ty >= word_i.den) begin
      ty = ty - word_i.den;
      qy = qy + QW'(1);
    end
    word_d.r_x = tx;
    word_d.r_y = ty;
    word_d.q_x = qx;
    word_d.q_y = qy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule
`default_nettype wire

>>> hdl/psd_sqrt_cell.sv
// One root digit of the distance square root
`default_nettype none
module psd_sqrt_cell
  import psd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire logic       valid_i,
  input  wire sqrt_word_t word_i,
  output logic            valid_o,
  output sqrt_word_t      word_o
);

  logic       valid_q;
  sqrt_word_t word_q, word_d;
  logic [REMW-1:0] rem_n, trial;

  always_comb begin
    word_d = word_i;
    rem_n  = {word_i.rem[REMW-3:0], word_i.s[SW-1:SW-2]};
    trial  = REMW'({word_i.r, 2'b01});
    if (rem_n >= trial) begin
      word_d.rem = rem_n - trial;
      word_d.r   = {word_i.r[RW-2:0], 1'b1};
    end else begin
      word_d.rem = rem_n;
      word_d.r   = {word_i.r[RW-2:0], 1'b0};
    end
    word_d.s = {word_i.s[SW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule
`default_nettype wire

>>> hdl/point_segment_distance_2d_core.sv
// Point to segment distance core: projection, quotient cell chain, root cell chain
// One word enters per cycle and one result leaves per cycle while the pipe
// advances; it holds 2*(CW+1) quotient cells plus (CW+1) root cells plus
// eleven fixed stages. The whole pipe advances while the output register
// is empty or being taken, so in_stall_o follows out_stall_i only when the
// output register holds a word.
`default_nettype none
module point_segment_distance_2d_core
  import psd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 opcode_i,
  input  wire logic signed [CW-1:0] point_x_i,
  input  wire logic signed [CW-1:0] point_y_i,
  input  wire logic signed [CW-1:0] start_x_i,
  input  wire logic signed [CW-1:0] start_y_i,
  input  wire logic signed [CW-1:0] end_x_i,
  input  wire logic signed [CW-1:0] end_y_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [OUTW-1:0]           distance_o,
  output logic signed [CW-1:0]      foot_x_o,
  output logic signed [CW-1:0]      foot_y_o,
  output logic                      off_segment_o
);

  logic adv;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q, out_v_q;

  // stage 1: differences
  side_t s1_q, s1_d;
  logic signed [DW-1:0] dx1_q, dy1_q, ux1_q, uy1_q;
  // stage 2: magnitudes and signs
  side_t s2_q, s2_d;
  logic [DW-1:0] mdx2_q, mdy2_q, mux2_q, muy2_q;
  logic n1_2_q, n2_2_q;
  // stage 3: products
  side_t s3_q;
  logic [DW-1:0] mdx3_q, mdy3_q;
  logic [PW-1:0] ddx3_q, ddy3_q, t1_3_q, t2_3_q;
  logic n1_3_q, n2_3_q;
  // stage 4: dot products
  side_t s4_q;
  logic [DW-1:0] mdx4_q, mdy4_q;
  logic [NW-1:0] den4_q;
  logic signed [NW-1:0] num4_q;
  // stage 5: classify, load quotient chain
  div_word_t dw5_d;
  // quotient chain
  logic      div_v [0:DIV_CELLS];
  div_word_t div_w [0:DIV_CELLS];
  // stage 6: rounded quotient
  side_t s6_q;
  logic [QW-1:0] qx6_q, qy6_q;
  // stage 7: foot
  tail_t t7_q;
  logic signed [CW-1:0] px7_q, py7_q;
  // stage 8: offsets
  tail_t t8_q;
  logic signed [DW-1:0] ax8_q, ay8_q;
  // stage 9: magnitudes
  tail_t t9_q;
  logic [DW-1:0] mx9_q, my9_q;
  // stage 10: sum of squares into root chain
  tail_t t10_q;
  logic [PW-1:0] sqx10_q, sqy10_q;
  sqrt_word_t sq_w [0:SQRT_CELLS];
  logic       sq_v [0:SQRT_CELLS];

  assign adv        = !out_v_q || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
      v6_q <= 1'b0; v7_q <= 1'b0; v8_q <= 1'b0; v9_q <= 1'b0; v10_q <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q; v5_q <= v4_q;
      v6_q <= div_v[DIV_CELLS]; v7_q <= v6_q; v8_q <= v7_q; v9_q <= v8_q;
      v10_q <= v9_q; out_v_q <= sq_v[SQRT_CELLS];
    end
  end

  always_comb begin
    s1_d        = '0;
    s1_d.strict = opcode_i;
    s1_d.px     = point_x_i;
    s1_d.py     = point_y_i;
    s1_d.sx     = start_x_i;
    s1_d.sy     = start_y_i;
    s1_d.ex     = end_x_i;
    s1_d.ey     = end_y_i;
  end

  always_comb begin
    s2_d       = s1_q;
    s2_d.neg_x = dx1_q[DW-1];
    s2_d.neg_y = dy1_q[DW-1];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q  <= s1_d;
      dx1_q <= DW'(end_x_i) - DW'(start_x_i);
      dy1_q <= DW'(end_y_i) - DW'(start_y_i);
      ux1_q <= DW'(point_x_i) - DW'(start_x_i);
      uy1_q <= DW'(point_y_i) - DW'(start_y_i);

      s2_q   <= s2_d;
      mdx2_q <= dx1_q[DW-1] ? -dx1_q : dx1_q;
      mdy2_q <= dy1_q[DW-1] ? -dy1_q : dy1_q;
      mux2_q <= ux1_q[DW-1] ? -ux1_q : ux1_q;
      muy2_q <= uy1_q[DW-1] ? -uy1_q : uy1_q;
      n1_2_q <= ux1_q[DW-1] ^ dx1_q[DW-1];
      n2_2_q <= uy1_q[DW-1] ^ dy1_q[DW-1];

      s3_q   <= s2_q;
      mdx3_q <= mdx2_q;
      mdy3_q <= mdy2_q;
      ddx3_q <= mdx2_q * mdx2_q;
      ddy3_q <= mdy2_q * mdy2_q;
      t1_3_q <= mux2_q * mdx2_q;
      t2_3_q <= muy2_q * mdy2_q;
      n1_3_q <= n1_2_q;
      n2_3_q <= n2_2_q;

      s4_q   <= s3_q;
      mdx4_q <= mdx3_q;
      mdy4_q <= mdy3_q;
      den4_q <= NW'(ddx3_q) + NW'(ddy3_q);
      num4_q <= (n1_3_q ? -$signed(NW'(t1_3_q)) : $signed(NW'(t1_3_q)))
              + (n2_3_q ? -$signed(NW'(t2_3_q)) : $signed(NW'(t2_3_q)));
    end
  end

  always_comb begin
    logic nz, neg, over;
    nz   = den4_q != '0;
    neg  = num4_q[NW-1];
    over = !neg && ($unsigned(num4_q) > den4_q);
    dw5_d              = '0;
    dw5_d.side         = s4_q;
    dw5_d.side.off     = nz && (neg || over);
    dw5_d.side.use_end = nz && over;
    dw5_d.side.proj    = nz && !neg && !over;
    dw5_d.d_x          = mdx4_q;
    dw5_d.d_y          = mdy4_q;
    dw5_d.den          = den4_q;
    dw5_d.num          = (nz && !neg && !over) ? $unsigned(num4_q) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_w[0] <= dw5_d;
    end
  end

  assign div_v[0] = v5_q;

  for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
    psd_div_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (adv),
      .add_step_i (1'((k % 2) == 1)),
      .valid_i    (div_v[k]),
      .word_i     (div_w[k]),
      .valid_o    (div_v[k+1]),
      .word_o     (div_w[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    logic [QW:0] fxw, fyw;
    if (adv) begin
      s6_q  <= div_w[DIV_CELLS].side;
      qx6_q <= div_w[DIV_CELLS].q_x
             + QW'({div_w[DIV_CELLS].r_x, 1'b0} >= {1'b0, div_w[DIV_CELLS].den});
      qy6_q <= div_w[DIV_CELLS].q_y
             + QW'({div_w[DIV_CELLS].r_y, 1'b0} >= {1'b0, div_w[DIV_CELLS].den});

      fxw = {{(QW+1-CW){s6_q.sx[CW-1]}}, s6_q.sx}
          + (s6_q.neg_x ? -{1'b0, qx6_q} : {1'b0, qx6_q});
      fyw = {{(QW+1-CW){s6_q.sy[CW-1]}}, s6_q.sy}
          + (s6_q.neg_y ? -{1'b0, qy6_q} : {1'b0, qy6_q});
      t7_q.strict <= s6_q.strict;
      t7_q.off    <= s6_q.off;
      px7_q       <= s6_q.px;
      py7_q       <= s6_q.py;
      if (s6_q.proj) begin
        t7_q.fx <= fxw[CW-1:0];
        t7_q.fy <= fyw[CW-1:0];
      end else if (s6_q.use_end) begin
        t7_q.fx <= s6_q.ex;
        t7_q.fy <= s6_q.ey;
      end else begin
        t7_q.fx <= s6_q.sx;
        t7_q.fy <= s6_q.sy;
      end

      t8_q  <= t7_q;
      ax8_q <= DW'(px7_q) - DW'(t7_q.fx);
      ay8_q <= DW'(py7_q) - DW'(t7_q.fy);

      t9_q  <= t8_q;
      mx9_q <= ax8_q[DW-1] ? -ax8_q : ax8_q;
      my9_q <= ay8_q[DW-1] ? -ay8_q : ay8_q;

      t10_q   <= t9_q;
      sqx10_q <= mx9_q * mx9_q;
      sqy10_q <= my9_q * my9_q;
    end
  end

  assign sq_v[0]      = v10_q;
  assign sq_w[0].s    = SW'(sqx10_q + sqy10_q);
  assign sq_w[0].rem  = '0;
  assign sq_w[0].r    = '0;
  assign sq_w[0].tail = t10_q;

  for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
    psd_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (sq_v[k]),
      .word_i  (sq_w[k]),
      .valid_o (sq_v[k+1]),
      .word_o  (sq_w[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    logic [RW:0] rr;
    if (adv) begin
      rr = {1'b0, sq_w[SQRT_CELLS].r}
         + (RW+1)'(sq_w[SQRT_CELLS].rem > REMW'(sq_w[SQRT_CELLS].r));
      if (sq_w[SQRT_CELLS].tail.strict && sq_w[SQRT_CELLS].tail.off) begin
        distance_o <= '1;
      end else if (rr > (RW+1)'({OUTW{1'b1}})) begin
        distance_o <= '1;
      end else begin
        distance_o <= OUTW'(rr);
      end
      foot_x_o      <= sq_w[SQRT_CELLS].tail.fx;
      foot_y_o      <= sq_w[SQRT_CELLS].tail.fy;
      off_segment_o <= sq_w[SQRT_CELLS].tail.off;
    end
  end

  assign out_valid_o = out_v_q;

endmodule
`default_nettype wire

>>> sim/tb_point_segment_distance_2d_core.sv
// Testbench for the point to segment distance core: random and directed queries, scoreboard check
`default_nettype none
module tb_point_segment_distance_2d_core
  import psd_pkg::*;
();

  localparam int  LIMIT    = 300000;
  localparam int  N_RANDOM = 400;
  localparam int  TAIL     = 150;
  localparam logic [OUTW-1:0] DIST_SAT = '1;
  localparam logic MODE_LOOSE  = 1'b0;
  localparam logic MODE_STRICT = 1'b1;
  localparam int  CMAX = (1 << (CW - 1)) - 1;
  localparam int  CMIN = -(1 << (CW - 1));

  typedef struct {
    logic                 strict;
    logic signed [CW-1:0] px, py, sx, sy, ex, ey;
  } seg_query_t;

  typedef struct {
    logic [OUTW-1:0]      len;
    logic signed [CW-1:0] fx, fy;
    logic                 off;
  } seg_answer_t;

  logic                 clk_i, rst_ni;
  logic                 in_valid_i, in_stall_o, opcode_i;
  logic signed [CW-1:0] point_x_i, point_y_i, start_x_i, start_y_i, end_x_i, end_y_i;
  logic                 out_valid_o, out_stall_i, off_segment_o;
  logic [OUTW-1:0]      distance_o;
  logic signed [CW-1:0] foot_x_o, foot_y_o;

  int send_idle, recv_idle, cycles;

  point_segment_distance_2d_core u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .opcode_i,
    .point_x_i, .point_y_i, .start_x_i, .start_y_i, .end_x_i, .end_y_i,
    .out_valid_o, .out_stall_i, .distance_o, .foot_x_o, .foot_y_o, .off_segment_o
  );

  function automatic logic [OUTW-1:0] rounded_length(longint ax, longint ay);
    logic [127:0] mx, my, s, r, c;
    mx = (ax < 0) ? -ax : ax;
    my = (ay < 0) ? -ay : ay;
    s = mx * mx + my * my;
    r = '0;
    for (int b = 36; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= s) r = c;
    end
    if (s - r * r > r) r = r + 1;
    if (r > {103'd0, DIST_SAT}) return DIST_SAT;
    return r[OUTW-1:0];
  endfunction

  function automatic longint rounded_share(longint num, longint d, longint den);
    logic [127:0] n, m, q;
    n = num;
    m = (d < 0) ? -d : d;
    q = (2 * n * m + den) / (2 * den);
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic seg_answer_t nearest_point(seg_query_t q);
    seg_answer_t a;
    longint dx, dy, ux, uy, num, den, fx, fy;
    dx = longint'(q.ex) - q.sx;
    dy = longint'(q.ey) - q.sy;
    ux = longint'(q.px) - q.sx;
    uy = longint'(q.py) - q.sy;
    den = dx * dx + dy * dy;
    num = ux * dx + uy * dy;
    fx = q.sx;
    fy = q.sy;
    a.off = 1'b0;
    if (den != 0) begin
      if (num < 0) begin
        a.off = 1'b1;
      end else if (num > den) begin
        a.off = 1'b1;
        fx = q.ex;
        fy = q.ey;
      end else begin
        fx = q.sx + rounded_share(num, dx, den);
        fy = q.sy + rounded_share(num, dy, den);
      end
    end
    a.fx = fx[CW-1:0];
    a.fy = fy[CW-1:0];
    a.len = (a.off && q.strict) ? DIST_SAT : rounded_length(q.px - fx, q.py - fy);
    return a;
  endfunction

  class foot_scoreboard;
    seg_answer_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function void note_query(seg_query_t q);
      pending.push_back(nearest_point(q));
    endfunction

    function void check_answer(seg_answer_t got);
      seg_answer_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word distance=%0d fx=%0d fy=%0d off=%0b",
                 $time, got.len, got.fx, got.fy, got.off);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.len !== want.len) begin
        $display("%0t: distance expected %0d actual %0d", $time, want.len, got.len);
        errors++;
      end
      if (got.fx !== want.fx) begin
        $display("%0t: foot_x expected %0d actual %0d", $time, want.fx, got.fx);
        errors++;
      end
      if (got.fy !== want.fy) begin
        $display("%0t: foot_y expected %0d actual %0d", $time, want.fy, got.fy);
        errors++;
      end
      if (got.off !== want.off) begin
        $display("%0t: off_segment expected %0b actual %0b", $time, want.off, got.off);
        errors++;
      end
    endfunction
  endclass

  foot_scoreboard sb = new();

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      sb.note_query('{opcode_i, point_x_i, point_y_i, start_x_i, start_y_i, end_x_i, end_y_i});
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_answer('{distance_o, foot_x_o, foot_y_o, off_segment_o});
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle);
  end

  task automatic send_query(seg_query_t q);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= q.strict;
    point_x_i  <= q.px;
    point_y_i  <= q.py;
    start_x_i  <= q.sx;
    start_y_i  <= q.sy;
    end_x_i    <= q.ex;
    end_y_i    <= q.ey;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic int span(int lim);
    return int'($urandom_range(2 * lim)) - lim;
  endfunction

  function automatic int edge_coord();
    case ($urandom_range(4))
      0: return CMIN;
      1: return CMAX;
      2: return 0;
      3: return -1;
      default: return int'($urandom);
    endcase
  endfunction

  function automatic seg_query_t random_query();
    seg_query_t q;
    int sx, sy, ex, ey, px, py;
    sx = span(1 << 21); sy = span(1 << 21);
    ex = span(1 << 21); ey = span(1 << 21);
    case ($urandom_range(6))
      0, 1: begin
        sx = $urandom; sy = $urandom; ex = $urandom; ey = $urandom;
        px = $urandom; py = $urandom;
      end
      2: begin
        sx = span(2048); sy = span(2048); ex = span(2048); ey = span(2048);
        px = span(4096); py = span(4096);
      end
      3: begin
        px = (sx + ex) / 2 + span(1 << 16);
        py = (sy + ey) / 2 + span(1 << 16);
      end
      4: begin
        ex = sx; ey = sy;
        px = $urandom; py = $urandom;
      end
      5: begin
        if ($urandom_range(1)) ex = sx; else ey = sy;
        px = span(1 << 22); py = span(1 << 22);
      end
      default: begin
        sx = edge_coord(); sy = edge_coord(); ex = edge_coord(); ey = edge_coord();
        px = edge_coord(); py = edge_coord();
      end
    endcase
    q.strict = $urandom_range(1);
    q.px = px; q.py = py; q.sx = sx; q.sy = sy; q.ex = ex; q.ey = ey;
    return q;
  endfunction

  seg_query_t directed[$];

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    out_stall_i = 1'b0;
    opcode_i    = MODE_LOOSE;
    point_x_i   = '0; point_y_i = '0;
    start_x_i   = '0; start_y_i = '0;
    end_x_i     = '0; end_y_i   = '0;
    cycles      = 0;
    send_idle   = 27;
    recv_idle   = 58;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int m = 0; m < 2; m++) begin
      logic md;
      md = m ? MODE_STRICT : MODE_LOOSE;
      directed.push_back('{md, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN});
      directed.push_back('{md, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX});
      directed.push_back('{md, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN});
      directed.push_back('{md, 0, 256, -512, 0, 512, 0});
      directed.push_back('{md, -1024, 300, -512, 0, 512, 0});
      directed.push_back('{md, 2048, -300, -512, 0, 512, 0});
      directed.push_back('{md, 700, 0, 0, -1000, 0, 1000});
      directed.push_back('{md, 5, 5, 3, 3, 3, 3});
      directed.push_back('{md, 1, 0, 0, 0, 3, 3});
      directed.push_back('{md, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX});
      directed.push_back('{md, 0, 0, CMIN, CMIN, CMAX, CMAX});
    end
    foreach (directed[i]) send_query(directed[i]);

    drain();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3) begin
        send_idle = 58;
        recv_idle = 27;
      end else if (i == 2 * N_RANDOM / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end
      send_query(random_query());
    end
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
